### design/ltps_pkg.sv
`timescale 1ns / 1ps

package ltps_pkg;

  localparam int CoefWidth  = 48;
  localparam int LimitWidth = 63;
  localparam int CfgWidth   = 63;
  localparam int IndexWidth = 3;

  localparam logic [IndexWidth-1:0] CFG_STIFFNESS  = 3'd0;
  localparam logic [IndexWidth-1:0] CFG_DAMPING    = 3'd1;
  localparam logic [IndexWidth-1:0] CFG_NOISE_GAIN = 3'd2;
  localparam logic [IndexWidth-1:0] CFG_DRIFT      = 3'd3;
  localparam logic [IndexWidth-1:0] CFG_MOD_DEPTH  = 3'd4;
  localparam logic [IndexWidth-1:0] CFG_LOSS_LIMIT = 3'd5;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q48_ONE = 64'sh0001_0000_0000_0000;
  localparam logic [LimitWidth-1:0] LOSS_LIMIT_RESET = 63'h0001_0000_0000_0000;

  // Right shift applied to the exact product.
  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_48
  } shift_t;

  typedef struct packed {
    logic   start;
    shift_t shift;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } mul_rsp_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) begin
      return a[63] ? SAT_MIN : SAT_MAX;
    end
    return s;
  endfunction

endpackage

### design/ltps_if.sv
`timescale 1ns / 1ps

interface ltps_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_sample;

  modport source (output valid, output noise_sample, input ready);
  modport sink (input valid, input noise_sample, output ready);
endinterface

interface ltps_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] position;
  logic signed [63:0] velocity;
  logic               lost;

  modport source (output valid, output position, output velocity, output lost, input ready);
  modport sink (input valid, input position, input velocity, input lost, output ready);
endinterface

### design/ltps_mul.sv
`timescale 1ns / 1ps

module ltps_mul (
  input  logic               clk,
  input  logic               rst,
  input  ltps_pkg::mul_req_t req,
  input  logic signed [63:0] op_a,
  input  logic signed [63:0] op_b,
  output ltps_pkg::mul_rsp_t rsp,
  output logic signed [63:0] product
);
  import ltps_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_PART,
    M_DRAIN,
    M_ROUND,
    M_FINISH
  } mstate_t;

  mstate_t        state;
  logic [1:0]     cnt;
  logic [63:0]    a_mag;
  logic [63:0]    b_mag;
  logic           neg;
  shift_t         shift;
  logic [63:0]    part;
  logic [1:0]     part_off;
  logic           part_valid;
  logic [127:0]   acc;
  logic           done;

  logic [31:0]    a_half;
  logic [31:0]    b_half;
  logic [63:0]    part_next;
  logic [127:0]   part_term;
  logic [127:0]   round_term;
  logic [63:0]    r_sel;
  logic           over;
  logic [63:0]    r_clamp;

  // Partial products in the order lo*lo, lo*hi, hi*lo, hi*hi.
  assign a_half    = cnt[1] ? a_mag[63:32] : a_mag[31:0];
  assign b_half    = cnt[0] ? b_mag[63:32] : b_mag[31:0];
  assign part_next = a_half * b_half;

  always_comb begin
    unique case (part_off)
      2'd0:    part_term = {64'd0, part};
      2'd1:    part_term = {32'd0, part, 32'd0};
      default: part_term = {part, 64'd0};
    endcase
  end

  always_comb begin
    round_term = '0;
    r_sel      = acc[63:0];
    over       = |acc[127:64];
    unique case (shift)
      SH_32: begin
        round_term = 128'd1 << 31;
        r_sel      = acc[95:32];
        over       = |acc[127:96];
      end
      SH_48: begin
        round_term = 128'd1 << 47;
        r_sel      = acc[111:48];
        over       = |acc[127:112];
      end
      default: begin
        round_term = '0;
        r_sel      = acc[63:0];
        over       = |acc[127:64];
      end
    endcase
  end

  assign r_clamp = (over || r_sel[63]) ? SAT_MAX : r_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= M_IDLE;
      cnt        <= '0;
      part_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            a_mag      <= mag(op_a);
            b_mag      <= mag(op_b);
            neg        <= op_a[63] ^ op_b[63];
            shift      <= req.shift;
            acc        <= '0;
            cnt        <= '0;
            part_valid <= 1'b0;
            state      <= M_PART;
          end
        end
        M_PART: begin
          part       <= part_next;
          part_off   <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          part_valid <= 1'b1;
          if (part_valid) begin
            acc <= acc + part_term;
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= M_DRAIN;
          end
        end
        M_DRAIN: begin
          acc        <= acc + part_term;
          part_valid <= 1'b0;
          state      <= M_ROUND;
        end
        M_ROUND: begin
          acc   <= acc + round_term;
          state <= M_FINISH;
        end
        M_FINISH: begin
          product <= neg ? (64'sd0 - r_clamp) : r_clamp;
          done    <= 1'b1;
          state   <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.busy = (state != M_IDLE);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done lasted more than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.start && state == M_IDLE) |=> rsp.busy)
    else $error("multiplier did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !rsp.busy)
    else $error("multiplier finished but still busy");

endmodule

### design/leapfrog_trapped_particle_step_unit.sv
`timescale 1ns / 1ps

// Leapfrog step unit for a trapped particle with parametric modulation, damping and noise.
// The sample channel brings one signed Q4.12 noise sample per transaction; each accepted
// transaction advances position and velocity (Q16.48) by one half kick, drift and second
// half kick, and the result channel returns the new position, velocity and lost flag.
// Coefficients are written over the plain write port; the user must write them only
// while the unit is idle, as the block itself does not enforce it. Each step runs
// twelve products on one shared 64x64 multiplier that forms four 32x32 partial
// products and then rounds and clamps. After the two kick updates, the loss check and
// the output load, the next sample can be accepted as soon as the result is presented.
// A lost particle is not advanced: its frozen state goes from idle straight to the
// output state. No new sample is taken until the step has loaded its output register.
// Reset clears position, velocity, the lost flag and all coefficients except the loss
// limit, which returns to 1.0. When the receiver stalls, the result is held in the output
// register while the next step is computed; that step then waits until the register frees.

module leapfrog_trapped_particle_step_unit (
  input  logic                             clk,
  input  logic                             rst,
  ltps_sample_if.sink                      sample_ch,
  ltps_result_if.source                    result_ch,
  input  logic                             cfg_we,
  input  logic [ltps_pkg::IndexWidth-1:0]  cfg_index,
  input  logic [ltps_pkg::CfgWidth-1:0]    cfg_data
);
  import ltps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOISE,
    ST_MX,
    ST_MXV,
    ST_FX,
    ST_STIFF,
    ST_DAMP,
    ST_KICK,
    ST_DRIFT,
    ST_CHECK,
    ST_OUT
  } step_state_t;

  // Configuration registers.
  logic [CoefWidth-1:0]         stiffness;
  logic [CoefWidth-1:0]         damping;
  logic [CoefWidth-1:0]         noise_gain;
  logic [CoefWidth-1:0]         drift;
  logic signed [CoefWidth-1:0]  modulation;
  logic [LimitWidth-1:0]        loss_limit;

  // Particle state and working registers.
  step_state_t        state;
  logic               issued;
  logic               second;
  logic signed [63:0] pos;
  logic signed [63:0] vel;
  logic               lost;
  logic signed [15:0] noise;
  logic signed [63:0] gn;
  logic signed [63:0] t;
  logic signed [63:0] kacc;
  logic signed [63:0] xk;
  logic signed [63:0] vk;

  // Output register.
  logic               out_valid;
  logic signed [63:0] out_pos;
  logic signed [63:0] out_vel;
  logic               out_lost;

  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  logic signed [63:0] mul_res;
  logic               mul_state;
  logic               consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness  <= '0;
      damping    <= '0;
      noise_gain <= '0;
      drift      <= '0;
      modulation <= '0;
      loss_limit <= LOSS_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STIFFNESS:  stiffness  <= cfg_data[CoefWidth-1:0];
        CFG_DAMPING:    damping    <= cfg_data[CoefWidth-1:0];
        CFG_NOISE_GAIN: noise_gain <= cfg_data[CoefWidth-1:0];
        CFG_DRIFT:      drift      <= cfg_data[CoefWidth-1:0];
        CFG_MOD_DEPTH:  modulation <= cfg_data[CoefWidth-1:0];
        CFG_LOSS_LIMIT: loss_limit <= cfg_data[LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier. The kick is
  // G*n - K*((1 + (M*x)*v)*x) - D*v, with the noise product formed once per step.
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    mul_req.shift = SH_32;
    mul_state     = 1'b1;
    unique case (state)
      ST_NOISE: begin
        mul_a         = {16'd0, noise_gain};
        mul_b         = {{44{noise[15]}}, noise, 4'd0};
        mul_req.shift = SH_0;
      end
      ST_MX: begin
        mul_a = {{16{modulation[CoefWidth-1]}}, modulation};
        mul_b = xk;
      end
      ST_MXV: begin
        mul_a         = t;
        mul_b         = vk;
        mul_req.shift = SH_48;
      end
      ST_FX: begin
        mul_a         = t;
        mul_b         = xk;
        mul_req.shift = SH_48;
      end
      ST_STIFF: begin
        mul_a = {16'd0, stiffness};
        mul_b = t;
      end
      ST_DAMP: begin
        mul_a = {16'd0, damping};
        mul_b = vk;
      end
      ST_DRIFT: begin
        mul_a = {16'd0, drift};
        mul_b = vk;
      end
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !issued;
  end

  assign consume = issued && mul_rsp.done;

  ltps_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .rsp     (mul_rsp),
    .product (mul_res)
  );

  // Step sequencer. The first half kick runs with second low and is followed by the
  // drift; the second half kick reuses the same states with the drifted position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      second    <= 1'b0;
      pos       <= '0;
      vel       <= '0;
      lost      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In ST_OUT the output register is reloaded in the same cycle it drains.
      if (result_ch.valid && result_ch.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      if (mul_req.start) begin
        issued <= 1'b1;
      end
      if (consume) begin
        issued <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_ch.valid) begin
            noise <= sample_ch.noise_sample;
            if (lost) begin
              state <= ST_OUT;
            end else begin
              xk     <= pos;
              vk     <= vel;
              second <= 1'b0;
              state  <= ST_NOISE;
            end
          end
        end
        ST_NOISE: begin
          if (consume) begin
            gn    <= mul_res;
            state <= ST_MX;
          end
        end
        ST_MX: begin
          if (consume) begin
            t     <= mul_res;
            state <= ST_MXV;
          end
        end
        ST_MXV: begin
          if (consume) begin
            t     <= sat_add(Q48_ONE, mul_res);
            state <= ST_FX;
          end
        end
        ST_FX: begin
          if (consume) begin
            t     <= mul_res;
            state <= ST_STIFF;
          end
        end
        ST_STIFF: begin
          if (consume) begin
            kacc  <= sat_sub(gn, mul_res);
            state <= ST_DAMP;
          end
        end
        ST_DAMP: begin
          if (consume) begin
            kacc  <= sat_sub(kacc, mul_res);
            state <= ST_KICK;
          end
        end
        ST_KICK: begin
          vk <= sat_add(vk, kacc);
          if (second) begin
            pos   <= xk;
            vel   <= sat_add(vk, kacc);
            state <= ST_CHECK;
          end else begin
            state <= ST_DRIFT;
          end
        end
        ST_DRIFT: begin
          if (consume) begin
            xk     <= sat_add(xk, mul_res);
            second <= 1'b1;
            state  <= ST_MX;
          end
        end
        ST_CHECK: begin
          // Strict compare of the magnitude against the limit; the flag is sticky.
          if (mag(pos) > {1'b0, loss_limit}) begin
            lost <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || result_ch.ready) begin
            out_pos   <= pos;
            out_vel   <= vel;
            out_lost  <= lost;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sample_ch.ready    = (state == ST_IDLE);
  assign result_ch.valid    = out_valid;
  assign result_ch.position = out_pos;
  assign result_ch.velocity = out_vel;
  assign result_ch.lost     = out_lost;

  a_lost_sticky: assert property (@(posedge clk) disable iff (rst) lost |=> lost)
    else $error("lost flag cleared without reset");
  a_lost_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && sample_ch.valid && lost) |=> (state == ST_OUT && $stable(pos)))
    else $error("lost particle was advanced");
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

endmodule

### sim/ltps_step_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the write port, keeps its own copy of the particle
// state and coefficients, and compares every step result with its prediction.
module ltps_step_checker (
  input  logic                            clk,
  input  logic                            rst,
  ltps_sample_if                          sample_ch,
  ltps_result_if                          result_ch,
  input  logic                            cfg_we,
  input  logic [ltps_pkg::IndexWidth-1:0] cfg_index,
  input  logic [ltps_pkg::CfgWidth-1:0]   cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              checked
);
  import ltps_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [63:0] position;
    logic signed [63:0] velocity;
    logic               lost;
  } particle_step_t;

  logic signed [63:0]    stiff_coef;
  logic signed [63:0]    damp_coef;
  logic signed [63:0]    gain_coef;
  logic signed [63:0]    drift_coef;
  logic signed [63:0]    depth_coef;
  logic [LimitWidth-1:0] loss_cap;

  logic signed [63:0] cur_pos;
  logic signed [63:0] cur_vel;
  logic               cur_lost;

  particle_step_t expected_steps[$];
  int             mismatch_total = 0;
  int             results_seen   = 0;

  function automatic logic [63:0] abs_mag(input logic signed [63:0] a);
    return a[63] ? ~a + 64'd1 : a;
  endfunction

  function automatic logic signed [63:0] clamp_wide(input logic [64:0] s);
    if (s[64] != s[63]) begin
      return s[64] ? SAT_MIN : SAT_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    return clamp_wide({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] clamp_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    return clamp_wide({a[63], a} - {b[63], b});
  endfunction

  // Exact product of magnitudes, rounded half away from zero on the shift,
  // clamped to the symmetric range, then given the product's sign.
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input shift_t sh);
    logic [127:0] full;
    logic [127:0] rounded;
    logic [63:0]  mag;
    full = {64'd0, abs_mag(a)} * {64'd0, abs_mag(b)};
    case (sh)
      SH_32:   rounded = (full + (128'd1 << 31)) >> 32;
      SH_48:   rounded = (full + (128'd1 << 47)) >> 48;
      default: rounded = full;
    endcase
    mag = (rounded > {64'd0, SAT_MAX}) ? SAT_MAX : rounded[63:0];
    return (a[63] ^ b[63]) ? 64'd0 - mag : mag;
  endfunction

  function automatic logic signed [63:0] kick_term(input logic signed [63:0] x,
                                                   input logic signed [63:0] v,
                                                   input logic signed [15:0] noise);
    logic signed [63:0] mx;
    logic signed [63:0] mxv;
    logic signed [63:0] spring;
    logic signed [63:0] spring_x;
    logic signed [63:0] restoring;
    logic signed [63:0] drag;
    logic signed [63:0] thermal;
    mx        = scaled_product(depth_coef, x, SH_32);
    mxv       = scaled_product(mx, v, SH_48);
    spring    = clamp_add(Q48_ONE, mxv);
    spring_x  = scaled_product(spring, x, SH_48);
    restoring = scaled_product(stiff_coef, spring_x, SH_32);
    drag      = scaled_product(damp_coef, v, SH_32);
    thermal   = scaled_product(gain_coef, {{44{noise[15]}}, noise, 4'b0000}, SH_0);
    return clamp_sub(clamp_sub(thermal, restoring), drag);
  endfunction

  function automatic particle_step_t advance_particle(input logic signed [15:0] noise);
    logic signed [63:0] v_half;
    logic signed [63:0] x_next;
    particle_step_t     outcome;
    if (!cur_lost) begin
      v_half   = clamp_add(cur_vel, kick_term(cur_pos, cur_vel, noise));
      x_next   = clamp_add(cur_pos, scaled_product(drift_coef, v_half, SH_32));
      cur_vel  = clamp_add(v_half, kick_term(x_next, v_half, noise));
      cur_pos  = x_next;
      cur_lost = abs_mag(x_next) > {1'b0, loss_cap};
    end
    outcome.position = cur_pos;
    outcome.velocity = cur_vel;
    outcome.lost     = cur_lost;
    return outcome;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_total++;
      if (mismatch_total <= ReportLimit) begin
        $display("[%0t] step result %0d, %s: expected %h, got %h",
                 $time, results_seen, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    particle_step_t want;
    if (rst) begin
      stiff_coef = '0;
      damp_coef  = '0;
      gain_coef  = '0;
      drift_coef = '0;
      depth_coef = '0;
      loss_cap   = LOSS_LIMIT_RESET;
      cur_pos    = '0;
      cur_vel    = '0;
      cur_lost   = 1'b0;
      expected_steps.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_steps.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= ReportLimit) begin
            $display("[%0t] result with no step outstanding: position %h velocity %h lost %b",
                     $time, result_ch.position, result_ch.velocity, result_ch.lost);
          end
        end else begin
          want = expected_steps.pop_front();
          results_seen++;
          check_field("position", want.position, result_ch.position);
          check_field("velocity", want.velocity, result_ch.velocity);
          check_field("lost", {63'd0, want.lost}, {63'd0, result_ch.lost});
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        expected_steps.push_back(advance_particle(sample_ch.noise_sample));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STIFFNESS:  stiff_coef = {{(64-CoefWidth){1'b0}}, cfg_data[CoefWidth-1:0]};
          CFG_DAMPING:    damp_coef  = {{(64-CoefWidth){1'b0}}, cfg_data[CoefWidth-1:0]};
          CFG_NOISE_GAIN: gain_coef  = {{(64-CoefWidth){1'b0}}, cfg_data[CoefWidth-1:0]};
          CFG_DRIFT:      drift_coef = {{(64-CoefWidth){1'b0}}, cfg_data[CoefWidth-1:0]};
          CFG_MOD_DEPTH:  depth_coef = {{(64-CoefWidth){cfg_data[CoefWidth-1]}},
                                        cfg_data[CoefWidth-1:0]};
          CFG_LOSS_LIMIT: loss_cap   = cfg_data[LimitWidth-1:0];
          default: ;
        endcase
      end
    end
    mismatches <= mismatch_total;
    pending    <= expected_steps.size();
    checked    <= results_seen;
  end

endmodule

### sim/leapfrog_trapped_particle_step_unit_tb.sv
`timescale 1ns / 1ps

// Top of the step unit testbench. It makes the clock and reset, feeds noise samples,
// drains results with its own stall pattern, programs the coefficients between
// phases and gives the verdict. All checking lives in the checker beside the unit.
module leapfrog_trapped_particle_step_unit_tb;
  import ltps_pkg::*;

  // Register slots past the loss limit exist on the port but hold nothing.
  localparam logic [IndexWidth-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [IndexWidth-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CoefWidth-1:0]  COEF_TOP       = {CoefWidth{1'b1}};
  localparam logic [CoefWidth-1:0]  DEPTH_MOST_NEG = {1'b1, {(CoefWidth-1){1'b0}}};
  localparam logic [CoefWidth-1:0]  DEPTH_MOST_POS = {1'b0, {(CoefWidth-1){1'b1}}};
  localparam logic [LimitWidth-1:0] LIMIT_TOP      = {LimitWidth{1'b1}};

  localparam int RandomItems  = 1600;
  // After the last result the unit is idle at once, so a short pause is enough
  // before the write port is touched.
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 150;

  // Noise for the gentle-trap coefficient set: both rails, zero, one LSB
  // either side of zero, alternating bit patterns and plus or minus one sigma.
  localparam logic signed [15:0] OPENING_NOISE [10] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh5555, 16'shAAAA, 16'sh1000, 16'shF000, 16'sh0000
  };

  typedef enum logic [1:0] {
    DRAIN_OPEN,
    DRAIN_HELD,
    DRAIN_CHOPPY
  } drain_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IndexWidth-1:0] cfg_index;
  logic [CfgWidth-1:0]   cfg_data;

  int mismatches;
  int pending;
  int checked;

  int samples_sent    = 0;
  int settings_loaded = 0;
  int burst_left      = 0;

  drain_mode_t drain_mode = DRAIN_OPEN;
  int          drain_left = 0;

  ltps_sample_if sample_ch ();
  ltps_result_if result_ch ();

  leapfrog_trapped_particle_step_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ltps_step_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .result_ch  (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The result side switches between windows of steady acceptance, long holds that
  // keep a finished step parked in the output register while the next one runs, and
  // a per-cycle coin toss. Holds stay shorter than a step so every phase gets hit.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (drain_left == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            drain_mode = DRAIN_OPEN;
            drain_left = $urandom_range(1, 300);
          end
          1: begin
            drain_mode = DRAIN_HELD;
            drain_left = $urandom_range(1, 100);
          end
          default: begin
            drain_mode = DRAIN_CHOPPY;
            drain_left = $urandom_range(1, 200);
          end
        endcase
      end
      drain_left--;
      case (drain_mode)
        DRAIN_OPEN: result_ch.ready <= 1'b1;
        DRAIN_HELD: result_ch.ready <= 1'b0;
        default:    result_ch.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Mostly a rough bell curve with sigma near 1.0 in Q4.12; one draw in eight spans
  // the whole 16-bit range so that every bit of the field toggles.
  function automatic logic signed [15:0] noise_draw();
    int acc;
    if ($urandom_range(0, 7) == 0) begin
      return 16'($urandom);
    end
    acc = $urandom_range(0, 8191) + $urandom_range(0, 8191) + $urandom_range(0, 8191)
        + $urandom_range(0, 8191) - 16382;
    return acc[15:0];
  endfunction

  // Samples go out in bursts; between bursts valid drops for a random gap that can
  // land anywhere within the unit's step, and a quarter of bursts follow with no gap.
  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 130);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_ch.valid        <= 1'b1;
    sample_ch.noise_sample <= value;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  // Stops the sample stream and waits until every step in flight has been returned,
  // so the coefficients never change under a running step.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IndexWidth-1:0] idx,
                           input logic [CfgWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all six registers back to back. The unused upper bits of the coefficient
  // writes sometimes carry junk, and now and then a spare slot gets a write too;
  // neither may disturb anything.
  task automatic load_coefficients(input logic [CoefWidth-1:0]  stiff,
                                   input logic [CoefWidth-1:0]  damp,
                                   input logic [CoefWidth-1:0]  gain,
                                   input logic [CoefWidth-1:0]  drift,
                                   input logic [CoefWidth-1:0]  depth,
                                   input logic [LimitWidth-1:0] limit);
    logic [CfgWidth-CoefWidth-1:0] junk;
    logic [CfgWidth-1:0]           noise_word;
    junk       = ($urandom_range(0, 1) == 1) ? (CfgWidth-CoefWidth)'($urandom) : '0;
    noise_word = CfgWidth'({$urandom, $urandom});
    write_reg(CFG_STIFFNESS, {junk, stiff});
    write_reg(CFG_DAMPING, {junk, damp});
    write_reg(CFG_NOISE_GAIN, {junk, gain});
    write_reg(CFG_DRIFT, {junk, drift});
    write_reg(CFG_MOD_DEPTH, {junk, depth});
    write_reg(CFG_LOSS_LIMIT, limit);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO, noise_word);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    logic [CoefWidth-1:0]  dt;
    logic [CoefWidth-1:0]  k_val;
    logic [CoefWidth-1:0]  d_val;
    logic [CoefWidth-1:0]  g_val;
    logic [CoefWidth-1:0]  m_val;
    logic [33:0]           depth_draw;
    logic [LimitWidth-1:0] lim_val;
    int                    random_sent;
    int                    phase_len;

    random_sent = 0;
    rst                    <= 1'b1;
    sample_ch.valid        <= 1'b0;
    sample_ch.noise_sample <= '0;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset all coefficients but the loss limit are zero, so a step must leave the
    // particle at rest whatever the noise.
    send_sample(16'sh7FFF);

    // Explicit zeros everywhere, loss limit included: a position of exactly zero
    // equals the limit and must not count as lost under the strict comparison.
    settle();
    load_coefficients('0, '0, '0, '0, '0, '0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);

    // A gentle trap: dt of 2^-8, moderate spring, light damping, unit modulation.
    settle();
    load_coefficients(48'h0000_0100_0000, 48'h0000_0002_0000, 48'h0000_0010_0000,
                      48'h0000_0100_0000, 48'h0001_0000_0000, LIMIT_TOP);
    foreach (OPENING_NOISE[i]) send_sample(OPENING_NOISE[i]);

    // Random phases. Each one draws a physically sensible coefficient set from a
    // random time step so the leapfrog stays stable and the particle keeps moving
    // rather than pinning at the rails. Loss limits stay far above the expected
    // amplitude, since a lost particle stays frozen until reset.
    while (random_sent < RandomItems) begin
      settle();
      dt    = 48'd1 << $urandom_range(20, 27);
      dt    = dt + $urandom_range(0, 1023) * (dt >> 10);
      k_val = ($urandom_range(2, 64) * dt) >> 4;
      d_val = ($urandom_range(0, 32) * dt) >> 8;
      g_val = ($urandom_range(0, 16) * dt) >> 8;
      depth_draw = 34'({$urandom, $urandom});
      m_val = ($urandom_range(0, 3) == 0) ? '0 : {{(CoefWidth-34){depth_draw[33]}}, depth_draw};
      lim_val = ($urandom_range(0, 2) == 0) ? LIMIT_TOP
                                            : (63'd1 << $urandom_range(56, 62));
      load_coefficients(k_val, d_val, g_val, dt, m_val, lim_val);
      phase_len = $urandom_range(100, 250);
      repeat (phase_len) begin
        send_sample(noise_draw());
        random_sent++;
      end
    end

    // Closing directed part. Every coefficient at full scale with the most negative
    // modulation, then the most positive: products clamp, sums saturate, and the
    // noise product itself overflows at the noise extremes.
    settle();
    load_coefficients(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, DEPTH_MOST_NEG, LIMIT_TOP);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    settle();
    load_coefficients(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, DEPTH_MOST_POS, LIMIT_TOP);
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0F0F);

    // A zero loss limit loses any particle that is off center. After that the state
    // is frozen and the following steps must return it unchanged with lost set.
    settle();
    load_coefficients(48'h0000_0100_0000, 48'h0000_0002_0000, 48'h0000_0010_0000,
                      48'h0000_0100_0000, '0, '0);
    send_sample(16'sh1234);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);

    settle();
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d noise samples under %0d coefficient settings; %0d step results checked.",
             samples_sent, settings_loaded, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d steps still outstanding.", mismatches, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

  // The timeout allows about fifteen times what a run needs with the longest gap
  // and hold on every step.
  initial begin
    #40_000_000;
    $display("Timed out with %0d steps outstanding.", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
design/ltps_pkg.sv
design/ltps_if.sv
design/ltps_mul.sv
design/leapfrog_trapped_particle_step_unit.sv
sim/ltps_step_checker.sv
sim/leapfrog_trapped_particle_step_unit_tb.sv
